// File: hw/rtl/qtns_pkg.sv
// ----------------------------------------------------------------------------
// qtns_pkg: shared types and constants of the neck servo angle unit
// Word layouts of both channels, the word passed from front to back, fixed
// point constants and the arctangent table of the CORDIC stages.
// ----------------------------------------------------------------------------
package qtns_pkg;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic [7:0] angle_left;
    logic [7:0] angle_right;
    logic [7:0] angle_front;
    logic [7:0] angle_back;
  } angles_t;

  // Rotated up-vector: rem = 2^60 - rz^2 feeds the square root.
  typedef struct packed {
    logic        [60:0] rem;
    logic signed [31:0] rz;
    logic signed [33:0] rx;
    logic signed [33:0] ry;
  } vec_t;

  localparam logic [1:0] CFG_NEUTRAL_LEFT  = 2'd0;
  localparam logic [1:0] CFG_NEUTRAL_RIGHT = 2'd1;
  localparam logic [1:0] CFG_NEUTRAL_FRONT = 2'd2;
  localparam logic [1:0] CFG_NEUTRAL_BACK  = 2'd3;

  localparam int CORDIC_ITERS = 16;
  localparam int VEC_W = 38;
  localparam int ZW    = 22;
  localparam int ROT_W = 33;
  localparam int A13_W = 18;

  localparam logic signed [ZW-1:0]    HALF_PI_16 = 22'sd102944;
  localparam logic signed [A13_W-1:0] PI_13      = 18'sd25736;
  localparam logic signed [A13_W-1:0] TWO_PI_13  = 18'sd51472;
  localparam logic signed [A13_W-1:0] HALF_PI_13 = 18'sd12868;
  localparam logic signed [ROT_W-1:0] CORDIC_K30 = 33'sd652032874;

  function automatic logic signed [ZW-1:0] atan_val(input logic [3:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      4'd0:    v = 22'sd51472;
      4'd1:    v = 22'sd30385;
      4'd2:    v = 22'sd16055;
      4'd3:    v = 22'sd8150;
      4'd4:    v = 22'sd4091;
      4'd5:    v = 22'sd2047;
      4'd6:    v = 22'sd1024;
      4'd7:    v = 22'sd512;
      4'd8:    v = 22'sd256;
      4'd9:    v = 22'sd128;
      4'd10:   v = 22'sd64;
      4'd11:   v = 22'sd32;
      4'd12:   v = 22'sd16;
      4'd13:   v = 22'sd8;
      4'd14:   v = 22'sd4;
      4'd15:   v = 22'sd2;
      default: v = 22'sd0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/qtns_fifo.sv
// ----------------------------------------------------------------------------
// qtns_fifo: two-entry word queue
// Decouples the pipeline sections; push and pop may happen in one cycle.
// ----------------------------------------------------------------------------
module qtns_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] mem [0:1];
  logic         wp_r, wp_nxt;
  logic         rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp_r];

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wdata;
    end
  end

endmodule

// File: hw/rtl/qtns_front.sv
// ----------------------------------------------------------------------------
// qtns_front: quaternion to rotated up-vector
// Five stages: component products, vector sums with the rz clamp, |rz|,
// rz squared, and the radicand of the tilt square root.
// ----------------------------------------------------------------------------
module qtns_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  qtns_pkg::quat_t in_q,
  output logic            out_vld,
  output qtns_pkg::vec_t  out_v
);

  localparam logic signed [34:0] ONE_Q30 = 35'sd1073741824;

  logic [4:0] vld_r;

  logic signed [31:0] p_xz_r, p_wy_r, p_yz_r, p_wx_r, p_xx_r, p_yy_r;

  logic signed [32:0] sum_rx, sum_ry;
  logic        [32:0] sum_sq;
  logic signed [34:0] rz_raw;
  logic signed [33:0] rx2_r, ry2_r;
  logic signed [31:0] rz2_r;

  logic signed [33:0] rx3_r, ry3_r;
  logic signed [31:0] rz3_r;
  logic        [30:0] mag3_r;

  logic signed [33:0] rx4_r, ry4_r;
  logic signed [31:0] rz4_r;
  logic        [61:0] mag2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_comb begin
    sum_rx = 33'(p_xz_r) + 33'(p_wy_r);
    sum_ry = 33'(p_yz_r) - 33'(p_wx_r);
    sum_sq = 33'(p_xx_r) + 33'(p_yy_r);
    rz_raw = ONE_Q30 - $signed({1'b0, sum_sq, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_xz_r <= in_q.quat_x * in_q.quat_z;
      p_wy_r <= in_q.quat_w * in_q.quat_y;
      p_yz_r <= in_q.quat_y * in_q.quat_z;
      p_wx_r <= in_q.quat_w * in_q.quat_x;
      p_xx_r <= in_q.quat_x * in_q.quat_x;
      p_yy_r <= in_q.quat_y * in_q.quat_y;

      rx2_r <= {sum_rx, 1'b0};
      ry2_r <= {sum_ry, 1'b0};
      // rz never exceeds one; only the lower bound needs the clamp.
      rz2_r <= (rz_raw < -ONE_Q30) ? 32'(-ONE_Q30) : 32'(rz_raw);

      rx3_r  <= rx2_r;
      ry3_r  <= ry2_r;
      rz3_r  <= rz2_r;
      mag3_r <= rz2_r[31] ? 31'(-rz2_r) : rz2_r[30:0];

      rx4_r  <= rx3_r;
      ry4_r  <= ry3_r;
      rz4_r  <= rz3_r;
      mag2_r <= mag3_r * mag3_r;

      out_v.rx  <= rx4_r;
      out_v.ry  <= ry4_r;
      out_v.rz  <= rz4_r;
      out_v.rem <= 61'((62'd1 << 60) - mag2_r);
    end
  end

  assign out_vld = vld_r[4];

endmodule

// File: hw/rtl/qtns_cordic_vec.sv
// ----------------------------------------------------------------------------
// qtns_cordic_vec: pipelined CORDIC arctangent
// One pre-rotation stage for a negative x, then one stage per iteration.
// The angle comes out in units of 2^-16 rad, zero for a zero vector.
// ----------------------------------------------------------------------------
module qtns_cordic_vec (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [qtns_pkg::VEC_W-1:0]    x_i,
  input  logic signed [qtns_pkg::VEC_W-1:0]    y_i,
  output logic signed [qtns_pkg::ZW-1:0]       z_o
);

  localparam int N = qtns_pkg::CORDIC_ITERS;

  logic signed [qtns_pkg::VEC_W-1:0] x_r [0:N];
  logic signed [qtns_pkg::VEC_W-1:0] y_r [0:N];
  logic signed [qtns_pkg::ZW-1:0]    z_r [0:N];
  logic        [N:0]                 zf_r;

  logic signed [qtns_pkg::VEC_W-1:0] x0, y0;
  logic signed [qtns_pkg::ZW-1:0]    z0;

  always_comb begin
    x0 = x_i;
    y0 = y_i;
    z0 = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x0 = y_i;
        y0 = -x_i;
        z0 = qtns_pkg::HALF_PI_16;
      end else begin
        x0 = -y_i;
        y0 = x_i;
        z0 = -qtns_pkg::HALF_PI_16;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]  <= x0;
      y_r[0]  <= y0;
      z_r[0]  <= z0;
      zf_r    <= {zf_r[N-1:0], (x_i == 0) && (y_i == 0)};
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[k-1] >= 0) begin
          x_r[k] <= x_r[k-1] + (y_r[k-1] >>> (k-1));
          y_r[k] <= y_r[k-1] - (x_r[k-1] >>> (k-1));
          z_r[k] <= z_r[k-1] + qtns_pkg::atan_val(4'(k-1));
        end else begin
          x_r[k] <= x_r[k-1] - (y_r[k-1] >>> (k-1));
          y_r[k] <= y_r[k-1] + (x_r[k-1] >>> (k-1));
          z_r[k] <= z_r[k-1] - qtns_pkg::atan_val(4'(k-1));
        end
      end
    end
  end

  assign z_o = zf_r[N] ? '0 : z_r[N];

endmodule

// File: hw/rtl/qtns_cordic_rot.sv
// ----------------------------------------------------------------------------
// qtns_cordic_rot: pipelined CORDIC cosine and sine
// The Q3.13 angle is wrapped and folded into the right half plane in the
// first stage; the fold flips the sign of both outputs. Outputs are Q.30.
// ----------------------------------------------------------------------------
module qtns_cordic_rot (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [qtns_pkg::A13_W-1:0]    a_i,
  output logic signed [qtns_pkg::ROT_W-1:0]    c_o,
  output logic signed [qtns_pkg::ROT_W-1:0]    s_o
);

  localparam int N = qtns_pkg::CORDIC_ITERS;

  logic signed [qtns_pkg::ROT_W-1:0] x_r [0:N];
  logic signed [qtns_pkg::ROT_W-1:0] y_r [0:N];
  logic signed [qtns_pkg::ZW-1:0]    z_r [0:N];
  logic        [N:0]                 neg_r;

  logic signed [qtns_pkg::A13_W-1:0] a1, a2;
  logic                              fold;

  always_comb begin
    a1   = (a_i > qtns_pkg::PI_13) ? a_i - qtns_pkg::TWO_PI_13 : a_i;
    a2   = a1;
    fold = 1'b0;
    if (a1 > qtns_pkg::HALF_PI_13) begin
      a2   = a1 - qtns_pkg::PI_13;
      fold = 1'b1;
    end else if (a1 < -qtns_pkg::HALF_PI_13) begin
      a2   = a1 + qtns_pkg::PI_13;
      fold = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= qtns_pkg::CORDIC_K30;
      y_r[0] <= '0;
      z_r[0] <= qtns_pkg::ZW'(a2) <<< 3;
      neg_r  <= {neg_r[N-1:0], fold};
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (z_r[k-1] >= 0) begin
          x_r[k] <= x_r[k-1] - (y_r[k-1] >>> (k-1));
          y_r[k] <= y_r[k-1] + (x_r[k-1] >>> (k-1));
          z_r[k] <= z_r[k-1] - qtns_pkg::atan_val(4'(k-1));
        end else begin
          x_r[k] <= x_r[k-1] + (y_r[k-1] >>> (k-1));
          y_r[k] <= y_r[k-1] - (x_r[k-1] >>> (k-1));
          z_r[k] <= z_r[k-1] + qtns_pkg::atan_val(4'(k-1));
        end
      end
    end
  end

  assign c_o = neg_r[N] ? -x_r[N] : x_r[N];
  assign s_o = neg_r[N] ? -y_r[N] : y_r[N];

endmodule

// File: hw/rtl/qtns_back.sv
// ----------------------------------------------------------------------------
// qtns_back: tilt, pan and rope servo angles
// Bit-per-stage square root, two arctangent CORDICs, tilt division by six,
// two cosine/sine CORDICs and a five-stage rope length datapath.
// ----------------------------------------------------------------------------
module qtns_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  qtns_pkg::vec_t    in_v,
  input  qtns_pkg::angles_t neutral,
  output logic              out_vld,
  output qtns_pkg::angles_t out_a
);

  localparam int SQ_N  = 31;
  localparam int CD_N  = qtns_pkg::CORDIC_ITERS + 1;
  localparam int LAT   = SQ_N + CD_N + 3 + CD_N + 5;

  logic [LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_vld};
    end
  end

  assign out_vld = vld_r[LAT-1];

  // Square root of the radicand, one result bit per stage.
  logic        [61:0] sv_r  [0:SQ_N-1];
  logic        [61:0] sr_r  [0:SQ_N-1];
  logic signed [31:0] crz_r [0:SQ_N-1];
  logic signed [33:0] crx_r [0:SQ_N-1];
  logic signed [33:0] cry_r [0:SQ_N-1];

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'd1 << (2 * (SQ_N - 1 - k));
    logic        [61:0] v_in, r_in, t;
    logic signed [31:0] rz_in;
    logic signed [33:0] rx_in, ry_in;
    if (k == 0) begin : g_first
      assign v_in  = {1'b0, in_v.rem};
      assign r_in  = '0;
      assign rz_in = in_v.rz;
      assign rx_in = in_v.rx;
      assign ry_in = in_v.ry;
    end else begin : g_next
      assign v_in  = sv_r[k-1];
      assign r_in  = sr_r[k-1];
      assign rz_in = crz_r[k-1];
      assign rx_in = crx_r[k-1];
      assign ry_in = cry_r[k-1];
    end
    assign t = r_in + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (v_in >= t) begin
          sv_r[k] <= v_in - t;
          sr_r[k] <= (r_in >> 1) + BIT;
        end else begin
          sv_r[k] <= v_in;
          sr_r[k] <= r_in >> 1;
        end
        crz_r[k] <= rz_in;
        crx_r[k] <= rx_in;
        cry_r[k] <= ry_in;
      end
    end
  end

  // Tilt and pan arctangents.
  logic signed [qtns_pkg::ZW-1:0] z_tilt, z_pan;

  qtns_cordic_vec u_vec_tilt (
    .clk (clk),
    .en  (en),
    .x_i (qtns_pkg::VEC_W'(crz_r[SQ_N-1])),
    .y_i ($signed({7'd0, sr_r[SQ_N-1][30:0]})),
    .z_o (z_tilt)
  );

  qtns_cordic_vec u_vec_pan (
    .clk (clk),
    .en  (en),
    .x_i (qtns_pkg::VEC_W'(cry_r[SQ_N-1])),
    .y_i (qtns_pkg::VEC_W'(crx_r[SQ_N-1])),
    .z_o (z_pan)
  );

  logic signed [qtns_pkg::A13_W-1:0] tilt13_r, pan13_r, pan13d1_r, pan13d2_r, t13_r;
  logic signed [qtns_pkg::ZW-1:0]    tz_round, pz_round;
  logic        [qtns_pkg::A13_W-1:0] tilt_mag;
  logic                              tneg_r;
  logic        [31:0]                tprod_r;
  logic        [15:0]                tquot;

  always_comb begin
    tz_round = (z_tilt + 22'sd4) >>> 3;
    pz_round = (z_pan + 22'sd4) >>> 3;
    tilt_mag = tilt13_r[qtns_pkg::A13_W-1] ? 18'(-tilt13_r) : 18'(tilt13_r);
    tquot    = tprod_r[31:16];
  end

  // Division by six toward zero: |tilt| times 2^16/6 rounded up is exact
  // for magnitudes below 2^15.
  always_ff @(posedge clk) begin
    if (en) begin
      tilt13_r  <= qtns_pkg::A13_W'(tz_round);
      pan13_r   <= qtns_pkg::PI_13 - qtns_pkg::A13_W'(pz_round);
      tneg_r    <= tilt13_r[qtns_pkg::A13_W-1];
      tprod_r   <= 32'(tilt_mag[16:0]) * 32'd10923;
      pan13d1_r <= pan13_r;
      t13_r     <= tneg_r ? -$signed({2'b00, tquot}) : $signed({2'b00, tquot});
      pan13d2_r <= pan13d1_r;
    end
  end

  logic signed [qtns_pkg::ROT_W-1:0] ct, st, pc, ps;

  qtns_cordic_rot u_rot_tilt (
    .clk (clk),
    .en  (en),
    .a_i (t13_r),
    .c_o (ct),
    .s_o (st)
  );

  qtns_cordic_rot u_rot_pan (
    .clk (clk),
    .en  (en),
    .a_i (pan13d2_r),
    .c_o (pc),
    .s_o (ps)
  );

  // Rope datapath. Ropes in order left, right, front, back use
  // cos(pan), -cos(pan), -sin(pan) and sin(pan).
  logic signed [qtns_pkg::ROT_W-1:0] csel [0:3];
  logic        [7:0]                 neut [0:3];
  logic        [7:0]                 ang_r [0:3];
  logic signed [qtns_pkg::ROT_W-1:0] ct1_r, st1_r;
  logic signed [47:0]                a_r;

  assign csel[0] = pc;
  assign csel[1] = -pc;
  assign csel[2] = -ps;
  assign csel[3] = ps;
  assign neut[0] = neutral.angle_left;
  assign neut[1] = neutral.angle_right;
  assign neut[2] = neutral.angle_front;
  assign neut[3] = neutral.angle_back;

  always_ff @(posedge clk) begin
    if (en) begin
      ct1_r <= ct;
      st1_r <= st;
      a_r   <= 48'(ct1_r) * 48'sd11520;
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_rope
    logic signed [38:0] xs;
    logic signed [15:0] x88_r;
    logic signed [47:0] b_r, ps_sum;
    logic signed [17:0] p88;
    logic signed [18:0] pd;
    logic signed [23:0] delta_r;
    logic signed [43:0] prod_r;
    logic signed [45:0] deg_sum;
    logic        [21:0] deg;

    always_comb begin
      xs      = (39'(csel[j]) * 39'sd20 + 39'sd2097152) >>> 22;
      ps_sum  = (a_r - b_r + 48'sd536870912) >>> 30;
      p88     = 18'(ps_sum);
      pd      = 19'(p88) - 19'sd11520;
      deg_sum = $signed({14'd0, neut[j], 24'd0}) + 46'(prod_r);
      deg     = deg_sum[45:24];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x88_r   <= 16'(xs) + 16'sd1280;
        b_r     <= 48'(x88_r) * 48'(st1_r);
        delta_r <= 24'(pd) * 24'sd12;
        prod_r  <= 44'(delta_r) * 44'sd187747;
        if (deg_sum[45]) begin
          ang_r[j] <= 8'd0;
        end else if (deg > 22'd180) begin
          ang_r[j] <= 8'd180;
        end else begin
          ang_r[j] <= deg[7:0];
        end
      end
    end
  end

  assign out_a.angle_left  = ang_r[0];
  assign out_a.angle_right = ang_r[1];
  assign out_a.angle_front = ang_r[2];
  assign out_a.angle_back  = ang_r[3];

endmodule

// File: hw/rtl/quaternion_to_neck_servo_angles_unit.sv
// ----------------------------------------------------------------------------
// quaternion_to_neck_servo_angles_unit: head quaternion to neck servo angles
// Input words are Q1.15 quaternions pushed with in_push while in_full is low.
// Each word yields one result word of four rope servo angles in whole
// degrees, read with out_pop while out_empty is low, in arrival order.
// Neutral angle registers are written through cfg_we/cfg_addr/cfg_wdata;
// the user must write them only while the unit holds no word; the block does
// not enforce this. Reset loads 95, 100, 100 and 95. From acceptance a word
// passes five front stages, a queue, 73 back stages (31-step square root, two
// 17-stage CORDIC sections, rope arithmetic) and the output queue before it
// shows at the result side. A new word is accepted every cycle while in_full
// is low. When the reader stops popping, the output queue fills, the back
// pipeline holds, the middle queue fills and in_full rises; nothing is
// dropped. Reset empties both queues and clears all pipeline valid bits.
// ----------------------------------------------------------------------------
module quaternion_to_neck_servo_angles_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  qtns_pkg::quat_t   in_data,
  output logic              in_full,
  input  logic              out_pop,
  output qtns_pkg::angles_t out_data,
  output logic              out_empty,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [7:0]        cfg_wdata
);

  qtns_pkg::angles_t neut_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neut_r.angle_left  <= 8'd95;
      neut_r.angle_right <= 8'd100;
      neut_r.angle_front <= 8'd100;
      neut_r.angle_back  <= 8'd95;
    end else if (cfg_we) begin
      case (cfg_addr)
        qtns_pkg::CFG_NEUTRAL_LEFT:  neut_r.angle_left  <= cfg_wdata;
        qtns_pkg::CFG_NEUTRAL_RIGHT: neut_r.angle_right <= cfg_wdata;
        qtns_pkg::CFG_NEUTRAL_FRONT: neut_r.angle_front <= cfg_wdata;
        qtns_pkg::CFG_NEUTRAL_BACK:  neut_r.angle_back  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic              f_en, f_vld, mid_full, mid_empty;
  qtns_pkg::vec_t    f_v, mid_v;
  logic              b_en, b_vld, out_full;
  qtns_pkg::angles_t b_out;

  assign f_en    = !mid_full;
  assign in_full = mid_full;

  qtns_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (f_en),
    .in_vld  (in_push),
    .in_q    (in_data),
    .out_vld (f_vld),
    .out_v   (f_v)
  );

  qtns_fifo #(.W($bits(qtns_pkg::vec_t))) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_en && f_vld),
    .wdata (f_v),
    .full  (mid_full),
    .pop   (b_en),
    .rdata (mid_v),
    .empty (mid_empty)
  );

  assign b_en = !out_full;

  qtns_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (b_en),
    .in_vld  (!mid_empty),
    .in_v    (mid_v),
    .neutral (neut_r),
    .out_vld (b_vld),
    .out_a   (b_out)
  );

  qtns_fifo #(.W($bits(qtns_pkg::angles_t))) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (b_en && b_vld),
    .wdata (b_out),
    .full  (out_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

  // A stalled back pipeline must keep its finished word intact.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!b_en && b_vld) |=> $stable(b_out))
    else $error("back pipeline word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.angle_left <= 8'd180) && (out_data.angle_right <= 8'd180)
                && (out_data.angle_front <= 8'd180) && (out_data.angle_back <= 8'd180))
    else $error("servo angle above 180 degrees");

endmodule

// File: dv/quaternion_to_neck_servo_angles_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_to_neck_servo_angles_checker: result checker of the neck unit
// Watches the input, result and register channels, computes the four servo
// angles of every accepted quaternion word in fixed point and compares each
// popped result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module quaternion_to_neck_servo_angles_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  qtns_pkg::quat_t   in_data,
  input  logic              in_full,
  input  logic              out_pop,
  input  qtns_pkg::angles_t out_data,
  input  logic              out_empty,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [7:0]        cfg_wdata,
  output int                fail_count,
  output int                pending
);

  localparam longint ATAN_Q16 [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024,
                                       512, 256, 128, 64, 32, 16, 8, 4, 2};
  localparam longint HALF_PI_Q16  = 102944;
  localparam int     PI_Q13       = 25736;
  localparam int     HALF_PI_Q13  = 12868;
  localparam longint GAIN_Q30     = 652032874;
  localparam longint DEG_PER_MM   = 187747;

  logic [7:0]        neutral_left, neutral_right, neutral_front, neutral_back;
  qtns_pkg::angles_t angles_due[$];

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Vectoring CORDIC, angle in units of 2^-16 rad.
  function automatic longint vec_atan2(longint y, longint x);
    longint z, t, nx, ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI_Q16;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI_Q16;
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z = z + ATAN_Q16[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z = z - ATAN_Q16[i];
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  function automatic int q16_to_q13(longint z);
    longint r;
    r = (z + 4) >>> 3;
    return int'(r);
  endfunction

  // Rotation CORDIC after folding the angle into [-pi/2, pi/2].
  function automatic void rot_cossin(int a, output longint c, output longint s);
    longint x, y, z, nx, ny;
    logic flip;
    x = GAIN_Q30; y = 0; flip = 1'b0;
    if (a > PI_Q13) a = a - 2 * PI_Q13;
    if (a > HALF_PI_Q13) begin
      a = a - PI_Q13; flip = 1'b1;
    end else if (a < -HALF_PI_Q13) begin
      a = a + PI_Q13; flip = 1'b1;
    end
    z = longint'(a) * 8;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z = z - ATAN_Q16[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z = z + ATAN_Q16[i];
      end
      x = nx; y = ny;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [7:0] rope_deg(logic [7:0] neutral, longint c30,
                                          longint ct, longint st);
    longint x88, p88, delta88, deg_sum, deg;
    x88 = ((c30 * 20 + (64'sd1 <<< 21)) >>> 22) + 5 * 256;
    p88 = (45 * 256 * ct - x88 * st + (64'sd1 <<< 29)) >>> 30;
    delta88 = 12 * (p88 - 45 * 256);
    deg_sum = (longint'({1'b0, neutral}) <<< 24) + delta88 * DEG_PER_MM;
    if (deg_sum < 0) return 8'd0;
    deg = deg_sum >>> 24;
    if (deg > 180) deg = 180;
    return deg[7:0];
  endfunction

  function automatic qtns_pkg::angles_t predict_angles(qtns_pkg::quat_t q);
    longint qx, qy, qz, qw, unit, rx, ry, rz, ct, st, pc, ps;
    longint unsigned mag, root;
    int tilt, seg, pan;
    qtns_pkg::angles_t a;
    qx = longint'(q.quat_x); qy = longint'(q.quat_y);
    qz = longint'(q.quat_z); qw = longint'(q.quat_w);
    unit = 64'sd1 <<< 30;
    rx = 2 * (qx * qz + qw * qy);
    ry = 2 * (qy * qz - qw * qx);
    rz = unit - 2 * (qx * qx + qy * qy);
    if (rz > unit) rz = unit;
    if (rz < -unit) rz = -unit;
    mag = (rz < 0) ? -rz : rz;
    root = floor_sqrt((64'd1 << 60) - mag * mag);
    tilt = q16_to_q13(vec_atan2(longint'(root), rz));
    seg = tilt / 6;
    pan = PI_Q13 - q16_to_q13(vec_atan2(rx, ry));
    rot_cossin(seg, ct, st);
    rot_cossin(pan, pc, ps);
    a.angle_left  = rope_deg(neutral_left, pc, ct, st);
    a.angle_right = rope_deg(neutral_right, -pc, ct, st);
    a.angle_front = rope_deg(neutral_front, -ps, ct, st);
    a.angle_back  = rope_deg(neutral_back, ps, ct, st);
    return a;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = angles_due.size();

  always @(posedge clk) begin
    qtns_pkg::angles_t want;
    if (!rst_n) begin
      neutral_left <= 8'd95;
      neutral_right <= 8'd100;
      neutral_front <= 8'd100;
      neutral_back <= 8'd95;
      angles_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          qtns_pkg::CFG_NEUTRAL_LEFT:  neutral_left <= cfg_wdata;
          qtns_pkg::CFG_NEUTRAL_RIGHT: neutral_right <= cfg_wdata;
          qtns_pkg::CFG_NEUTRAL_FRONT: neutral_front <= cfg_wdata;
          qtns_pkg::CFG_NEUTRAL_BACK:  neutral_back <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_push && !in_full)
        angles_due.insert(angles_due.size(), predict_angles(in_data));
      if (out_pop && !out_empty) begin
        if (angles_due.size() == 0) begin
          report_mismatch("unexpected result word", out_data, 0);
        end else begin
          want = angles_due.pop_front();
          if (out_data.angle_left != want.angle_left)
            report_mismatch("angle_left", out_data.angle_left, want.angle_left);
          if (out_data.angle_right != want.angle_right)
            report_mismatch("angle_right", out_data.angle_right, want.angle_right);
          if (out_data.angle_front != want.angle_front)
            report_mismatch("angle_front", out_data.angle_front, want.angle_front);
          if (out_data.angle_back != want.angle_back)
            report_mismatch("angle_back", out_data.angle_back, want.angle_back);
        end
      end
    end
  end

endmodule

// File: dv/quaternion_to_neck_servo_angles_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_to_neck_servo_angles_unit_test: top of the neck unit testbench
// Drives directed quaternion words and random bursts through several neutral
// angle settings, pops result words on a random pattern with one long
// hold-off, and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module quaternion_to_neck_servo_angles_unit_test;

  localparam int RUN_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_push = 1'b0;
  qtns_pkg::quat_t   in_data = '0;
  logic              in_full;
  logic              out_pop = 1'b0;
  qtns_pkg::angles_t out_data;
  logic              out_empty;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_addr = qtns_pkg::CFG_NEUTRAL_LEFT;
  logic [7:0]        cfg_wdata = '0;
  int                fail_count;
  int                pending;
  int                words_sent = 0;
  int                cycle_count = 0;

  quaternion_to_neck_servo_angles_unit DUT (.*);
  quaternion_to_neck_servo_angles_checker u_checker (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_word(qtns_pkg::quat_t q);
    in_push <= 1'b1;
    in_data <= q;
    @(posedge clk);
    while (in_full) @(posedge clk);
    words_sent++;
  endtask

  // Rotation by a random angle about a random axis, scaled to Q1.15.
  function automatic qtns_pkg::quat_t unit_quat();
    real ax, ay, az, norm, half, s;
    qtns_pkg::quat_t q;
    ax = real'($urandom_range(0, 2000)) - 1000.0;
    ay = real'($urandom_range(0, 2000)) - 1000.0;
    az = real'($urandom_range(0, 2000)) - 1000.0;
    norm = $sqrt(ax * ax + ay * ay + az * az);
    if (norm < 1.0) begin
      ax = 0.0; ay = 0.0; az = 1.0; norm = 1.0;
    end
    half = real'($urandom_range(0, 62831)) / 20000.0;
    s = $sin(half) * 32767.0 / norm;
    q.quat_x = 16'($rtoi(ax * s));
    q.quat_y = 16'($rtoi(ay * s));
    q.quat_z = 16'($rtoi(az * s));
    q.quat_w = 16'($rtoi($cos(half) * 32767.0));
    return q;
  endfunction

  function automatic qtns_pkg::quat_t random_quat();
    qtns_pkg::quat_t q;
    if ($urandom_range(0, 9) < 7) begin
      q = unit_quat();
    end else begin
      q = qtns_pkg::quat_t'({$urandom(), $urandom()});
    end
    return q;
  endfunction

  task automatic write_neutrals(logic [7:0] l, logic [7:0] r, logic [7:0] f,
                                logic [7:0] b);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= qtns_pkg::CFG_NEUTRAL_LEFT; cfg_wdata <= l;
    @(posedge clk);
    cfg_addr <= qtns_pkg::CFG_NEUTRAL_RIGHT; cfg_wdata <= r;
    @(posedge clk);
    cfg_addr <= qtns_pkg::CFG_NEUTRAL_FRONT; cfg_wdata <= f;
    @(posedge clk);
    cfg_addr <= qtns_pkg::CFG_NEUTRAL_BACK; cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Lowers push, waits for every result word and lets the pipeline settle.
  // An edge passes first so the checker has logged the last accepted word.
  task automatic quiesce();
    in_push <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_random(int count);
    int left, burst, gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      repeat (burst) send_word(random_quat());
      left -= burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    qtns_pkg::quat_t directed [$];
    logic [7:0] setting [5][4];
    directed = '{
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd0, 16'sd0, 16'sd32767},
      '{16'sd0, 16'sd0, 16'sd0, -16'sd32768},
      '{16'sd32767, 16'sd0, 16'sd0, 16'sd0},
      '{-16'sd32768, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd32767, 16'sd0, 16'sd0},
      '{16'sd0, -16'sd32768, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd0, 16'sd32767, 16'sd0},
      '{16'sd0, 16'sd0, -16'sd32768, 16'sd0},
      '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768},
      '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767},
      '{16'sd23170, 16'sd0, 16'sd0, 16'sd23170},
      '{16'sd0, 16'sd23170, 16'sd0, 16'sd23170},
      '{-16'sd23170, 16'sd0, 16'sd0, 16'sd23170},
      '{16'sd0, -16'sd23170, 16'sd0, 16'sd23170},
      '{16'sd5000, 16'sd3000, 16'sd0, 16'sd32000},
      '{16'sd0, 16'sd0, 16'sd23170, 16'sd23170},
      '{16'sd32767, -16'sd32768, 16'sd1, -16'sd1},
      '{16'sd12000, -16'sd9000, 16'sd20000, 16'sd15000},
      '{16'sd1, 16'sd0, 16'sd0, 16'sd32767}
    };
    setting = '{'{8'd0, 8'd0, 8'd0, 8'd0},
                '{8'd180, 8'd180, 8'd180, 8'd180},
                '{8'd255, 8'd255, 8'd255, 8'd255},
                '{8'd95, 8'd100, 8'd100, 8'd95},
                '{8'd10, 8'd170, 8'd60, 8'd128}};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Reset values first, then the extremes, including values past 180, then the reset values again and a mixed set.
    foreach (directed[i]) send_word(directed[i]);
    send_random(260);
    for (int p = 0; p < 5; p++) begin
      quiesce();
      write_neutrals(setting[p][0], setting[p][1], setting[p][2], setting[p][3]);
      foreach (directed[i]) if (p < 2) send_word(directed[i]);
      send_random(250);
    end
    quiesce();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Reader: random pop patterns, and one long hold-off so the input stalls.
  initial begin
    int mode;
    bit held;
    held = 1'b0;
    wait (rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(10, 60)) begin
        @(posedge clk);
        case (mode)
          0: out_pop <= 1'b1;
          1: out_pop <= 1'($urandom_range(0, 1));
          2: out_pop <= ($urandom_range(0, 7) == 0);
          default: out_pop <= ($urandom_range(0, 3) != 0);
        endcase
      end
      if (!held && words_sent > 400) begin
        held = 1'b1;
        @(posedge clk);
        out_pop <= 1'b0;
        repeat (600) @(posedge clk);
      end
    end
  end

endmodule

// File: filelist.f
hw/rtl/qtns_pkg.sv
hw/rtl/qtns_fifo.sv
hw/rtl/qtns_front.sv
hw/rtl/qtns_cordic_vec.sv
hw/rtl/qtns_cordic_rot.sv
hw/rtl/qtns_back.sv
hw/rtl/quaternion_to_neck_servo_angles_unit.sv
dv/quaternion_to_neck_servo_angles_checker.sv
dv/quaternion_to_neck_servo_angles_unit_test.sv
